// ----- sv/tplc_pkg.sv -----
// Package for the tuner PLL and low-pass code calculator.
// Holds the pipeline word type, stage indexes, reciprocal constants and the base-code table.
// No dependencies.
package tplc_pkg;

  localparam int NST      = 18;  // pipeline stages, last one is the output register
  localparam int DIV_BITS = 9;   // quotient bits of the coarse-code dividers
  localparam int DIV_S0   = 8;   // first divider stage

  localparam logic [21:0] DIV4_LIMIT = 22'd1103000;
  // reciprocals: sr/8/125, num/8/3375, w/7, y/25, u/675, p/100
  localparam logic [23:0] REC_125  = 24'd8589935;   // shift 30
  localparam logic [24:0] REC_3375 = 25'd20361327;  // shift 36
  localparam logic [27:0] REC_7    = 28'd153391690; // shift 30
  localparam logic [21:0] REC_25   = 22'd2684355;   // shift 26
  localparam logic [14:0] REC_675  = 15'd24856;     // shift 24
  localparam logic [12:0] REC_100  = 13'd5243;      // shift 19
  localparam logic [17:0] FINE_STEP = 18'd172800;   // 2 * 3200 * 27000 / 1000

  typedef struct packed {
    logic        d4;
    logic [24:0] z;
    logic [22:0] xs;
    logic [5:0]  v;
    logic [5:0]  gain;
    logic        retry;
    logic        vco;
    logic [49:0] ndp;
    logic [46:0] ksrp;
    logic [13:0] word;
    logic [26:0] w;
    logic [23:0] k135;
    logic        ks_lo;
    logic [54:0] tp;
    logic [42:0] bwp;
    logic [21:0] tuned;
    logic [15:0] bw;
    logic [5:0]  base;
    logic [21:0] x;
    logic [13:0] cp;
    logic [13:0] np;
    logic [29:0] up;
    logic [26:0] cmxp;
    logic [26:0] cmnp;
    logic [5:0]  cmax;
    logic [5:0]  cmin;
    logic [4:0]  fine;
    logic [21:0] r1;
    logic [21:0] r2;
    logic [16:0] den;
    logic [8:0]  q1;
    logic [8:0]  q2;
    logic [5:0]  coarse;
  } pipe_t;

  // 9522 / (2v + 151)
  function automatic logic [5:0] base_code(input logic [5:0] v);
    logic [5:0] b;
    case (v)
      6'd0: b = 6'd63;   6'd1: b = 6'd62;   6'd2: b = 6'd61;   6'd3: b = 6'd60;
      6'd4: b = 6'd59;   6'd5: b = 6'd59;   6'd6: b = 6'd58;   6'd7: b = 6'd57;
      6'd8: b = 6'd57;   6'd9: b = 6'd56;   6'd10: b = 6'd55;  6'd11: b = 6'd55;
      6'd12: b = 6'd54;  6'd13: b = 6'd53;  6'd14: b = 6'd53;  6'd15: b = 6'd52;
      6'd16: b = 6'd52;  6'd17: b = 6'd51;  6'd18: b = 6'd50;  6'd19: b = 6'd50;
      6'd20: b = 6'd49;  6'd21: b = 6'd49;  6'd22: b = 6'd48;  6'd23: b = 6'd48;
      6'd24: b = 6'd47;  6'd25: b = 6'd47;  6'd26: b = 6'd46;  6'd27: b = 6'd46;
      6'd28: b = 6'd46;  6'd29: b = 6'd45;  6'd30: b = 6'd45;  6'd31: b = 6'd44;
      6'd32: b = 6'd44;  6'd33: b = 6'd43;  6'd34: b = 6'd43;  6'd35: b = 6'd43;
      6'd36: b = 6'd42;  6'd37: b = 6'd42;  6'd38: b = 6'd41;  6'd39: b = 6'd41;
      6'd40: b = 6'd41;  6'd41: b = 6'd40;  6'd42: b = 6'd40;  6'd43: b = 6'd40;
      6'd44: b = 6'd39;  6'd45: b = 6'd39;  6'd46: b = 6'd39;  6'd47: b = 6'd38;
      6'd48: b = 6'd38;  6'd49: b = 6'd38;  6'd50: b = 6'd37;  6'd51: b = 6'd37;
      6'd52: b = 6'd37;  6'd53: b = 6'd37;  6'd54: b = 6'd36;  6'd55: b = 6'd36;
      6'd56: b = 6'd36;  6'd57: b = 6'd35;  6'd58: b = 6'd35;  6'd59: b = 6'd35;
      6'd60: b = 6'd35;  6'd61: b = 6'd34;  6'd62: b = 6'd34;
      default: b = 6'd34;
    endcase
    return b;
  endfunction

endpackage

// ----- sv/tuner_pll_and_lpf_code_calc_top.sv -----
// Top level of the tuner PLL and low-pass code calculator.
// Uses tplc_pkg (pipeline word type, constants, base-code table).
//
// Usage:
//   One request word enters on the in_ stream: RF frequency, symbol rate,
//   filter and gain calibration readings, and two PLL status bytes. One result
//   word leaves on the out_ stream: divide-by-four mode, PLL word, tuned
//   frequency, retry and VCO flags, coarse and fine low-pass codes, gain code.
//   Throughput is one word per cycle while the receiver does not stall the
//   output: the 18-stage pipeline holds up to 18 requests in flight. Every
//   division by a constant is a reciprocal multiply; the two coarse-code
//   divisions by the bandwidth run as bit-per-stage restoring dividers over
//   nine stages, both candidates (fine and fine+1) side by side.
//   Reset clears all valid bits; the pipeline comes out empty. When the
//   receiver holds out_tready low with a word waiting, the whole pipeline,
//   bubbles included, holds and in_tready drops; nothing is lost or repeated.
//   While the output register is empty the pipe keeps advancing.
module tuner_pll_and_lpf_code_calc_top
  import tplc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // freq_khz[21:0], sym_rate[47:22], filt_cal_a[53:48], filt_cal_b[59:54],
  // gain_cal_a[65:60], gain_cal_b[71:66], pll_stat_first[79:72], pll_stat_second[87:80]
  input  logic [87:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // div_four[0], pll_word[14:1], tuned_khz[36:15], pll_retry[37], vco_adjust[38],
  // lpf_coarse[44:39], lpf_fine[49:45], gain_code[55:50]
  output logic [55:0] out_tdata
);

  pipe_t           st_r   [NST];
  pipe_t           st_nxt [NST];
  logic [NST-1:0]  vld_r;
  logic            adv;

  // advance whenever the output register is free or being drained
  assign adv       = !vld_r[NST-1] || out_tready;
  assign in_tready = adv;

  always_comb begin
    logic [21:0] freq;
    logic [25:0] sr;
    logic [6:0]  sum_f;
    logic [6:0]  sum_g;
    logic [27:0] num;
    logic [13:0] nd_raw;
    logic [13:0] nd;
    logic [16:0] ksr;
    logic [17:0] bw_sum;
    logic [16:0] bw0;
    logic [21:0] t_sum;
    logic [5:0]  cm;
    logic [4:0]  fn;
    logic [21:0] n1;
    logic [24:0] dsh;
    logic        sel;
    logic [8:0]  q;
    int          k;
    int          b;

    st_nxt[0] = '0;
    for (int i = 1; i < NST; i++) begin
      st_nxt[i] = st_r[i-1];
    end

    // stage 0: capture, flags, averages, PLL numerator
    freq  = in_tdata[21:0];
    sr    = in_tdata[47:22];
    sum_f = {1'b0, in_tdata[53:48]} + {1'b0, in_tdata[59:54]};
    sum_g = {1'b0, in_tdata[65:60]} + {1'b0, in_tdata[71:66]};
    st_nxt[0].d4    = freq < DIV4_LIMIT;
    num   = st_nxt[0].d4 ? 28'(freq) * 28'd56 : 28'(freq) * 28'd28;
    st_nxt[0].z     = num[27:3];
    st_nxt[0].xs    = sr[25:3];
    st_nxt[0].v     = sum_f[6:1];
    st_nxt[0].gain  = sum_g[6:1];
    st_nxt[0].retry = !in_tdata[78];
    st_nxt[0].vco   = in_tdata[84:80] > 5'd19;

    // stage 1: reciprocal products for divider and kilo-symbol rate
    st_nxt[1].ndp  = 50'(st_r[0].z) * 50'(REC_3375);
    st_nxt[1].ksrp = 47'(st_r[0].xs) * 47'(REC_125);

    // stage 2: even divider, PLL word, tuned-frequency numerator, bandwidth product
    nd_raw = st_r[1].ndp[49:36];
    nd     = nd_raw + {13'd0, nd_raw[0]};
    if (nd < 14'd4095) begin
      st_nxt[2].word = nd - 14'd1024;
    end else if (nd < 14'd6143) begin
      st_nxt[2].word = nd + 14'd1024;
    end else begin
      st_nxt[2].word = nd + 14'd3072;
    end
    st_nxt[2].w     = st_r[1].d4 ? 27'(nd[13:1]) * 27'd6750 : 27'(nd[13:1]) * 27'd13500;
    ksr             = st_r[1].ksrp[46:30];
    st_nxt[2].k135  = 24'(ksr) * 24'd135;
    st_nxt[2].ks_lo = ksr < 17'd5000;

    // stage 3: divide by 7 and by 25
    st_nxt[3].tp  = 55'(st_r[2].w) * 55'(REC_7);
    st_nxt[3].bwp = 43'(st_r[2].k135[23:3]) * 43'(REC_25);

    // stage 4: tuned frequency, clamped bandwidth, base code
    st_nxt[4].tuned = st_r[3].tp[51:30];
    bw0    = st_r[3].bwp[42:26];
    bw_sum = 18'(bw0) + (st_r[3].ks_lo ? 18'd5000 : 18'd2000);
    if (bw_sum < 18'd7000) begin
      st_nxt[4].bw = 16'd7000;
    end else if (bw_sum > 18'd40000) begin
      st_nxt[4].bw = 16'd40000;
    end else begin
      st_nxt[4].bw = bw_sum[15:0];
    end
    st_nxt[4].base = base_code(st_r[3].v);

    // stage 5: base * bandwidth, coarse limit numerators
    st_nxt[5].x  = 22'(st_r[4].base) * 22'(st_r[4].bw);
    st_nxt[5].cp = 14'(st_r[4].base) * 14'd135;
    st_nxt[5].np = 14'(st_r[4].base) * 14'd78;

    // stage 6: rounded fine divide and coarse limits by reciprocal
    t_sum = st_r[5].x + 22'd43200;
    st_nxt[6].up   = 30'(t_sum[21:7]) * 30'(REC_675);
    st_nxt[6].cmxp = 27'(st_r[5].cp) * 27'(REC_100);
    st_nxt[6].cmnp = 27'(st_r[5].np) * 27'(REC_100);

    // stage 7: clamp fine, set up both coarse divisions
    fn = st_r[6].up[28:24];
    if (fn > 5'd23) begin
      fn = 5'd23;
    end
    if (fn < 5'd1) begin
      fn = 5'd1;
    end
    cm = (st_r[6].cmxp[26:19] > 8'd63) ? 6'd63 : st_r[6].cmxp[24:19];
    st_nxt[7].cmax = cm;
    st_nxt[7].cmin = st_r[6].cmnp[24:19];
    st_nxt[7].fine = fn;
    n1 = 22'(fn) * 22'(FINE_STEP) + 22'(st_r[6].bw);
    st_nxt[7].r1  = n1;
    st_nxt[7].r2  = n1 + 22'(FINE_STEP);
    st_nxt[7].den = {st_r[6].bw, 1'b0};
    st_nxt[7].q1  = '0;
    st_nxt[7].q2  = '0;

    // stages 8..16: one quotient bit per stage, MSB first
    for (int s = 0; s < DIV_BITS; s++) begin
      k   = DIV_S0 + s;
      b   = DIV_BITS - 1 - s;
      dsh = 25'(st_r[k-1].den) << b;
      if ({3'b0, st_r[k-1].r1} >= dsh) begin
        st_nxt[k].r1    = 22'({3'b0, st_r[k-1].r1} - dsh);
        st_nxt[k].q1[b] = 1'b1;
      end
      if ({3'b0, st_r[k-1].r2} >= dsh) begin
        st_nxt[k].r2    = 22'({3'b0, st_r[k-1].r2} - dsh);
        st_nxt[k].q2[b] = 1'b1;
      end
    end

    // last stage: bump fine once if coarse falls short, cut to coarse maximum
    sel = st_r[NST-2].q1 < {3'b0, st_r[NST-2].cmin};
    q   = sel ? st_r[NST-2].q2 : st_r[NST-2].q1;
    st_nxt[NST-1].fine   = st_r[NST-2].fine + {4'd0, sel};
    st_nxt[NST-1].coarse = (q > {3'b0, st_r[NST-2].cmax}) ? st_r[NST-2].cmax : q[5:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NST; i++) begin
        st_r[i] <= st_nxt[i];
      end
    end
  end

  assign out_tvalid = vld_r[NST-1];
  assign out_tdata  = {st_r[NST-1].gain, st_r[NST-1].fine, st_r[NST-1].coarse,
                       st_r[NST-1].vco, st_r[NST-1].retry, st_r[NST-1].tuned,
                       st_r[NST-1].word, st_r[NST-1].d4};

endmodule
